// File: rtl/core/btem_pkg.sv
package btem_pkg;

    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int KERN_ENTRIES_DEF  = 256;
    localparam int KERN_CHUNK        = 4;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic signed [20:0] W21_MAX = 21'sd1048575;
    localparam logic signed [20:0] W21_MIN = -21'sd1048576;
    localparam logic [19:0]        H20_MAX = 20'd1048575;

    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_END   = 2'd1,
        ACT_GLYPH = 2'd2,
        ACT_KERN  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_LINE_HEIGHT = 2'd0,
        REG_WRAP_ENABLE = 2'd1,
        REG_MAX_WIDTH   = 2'd2
    } reg_index_t;

    typedef struct packed {
        action_t            action;
        logic [7:0]         code;
        logic [7:0]         second_code;
        logic signed [15:0] amount;
        logic signed [15:0] glyph_height;
    } item_t;

    typedef struct packed {
        logic signed [20:0] block_width;
        logic [19:0]        block_height;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GLYPH_RD,
        ST_SCAN,
        ST_APPLY,
        ST_END_MUL,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [9:0]  line_height;
        logic        wrap_enable;
        logic [15:0] max_width;
    } cfg_t;

endpackage

// File: rtl/core/btem_stream_if.sv
interface btem_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/btem_front.sv
module btem_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    btem_stream_if.sink            in_ch,
    output logic                   q_valid,
    output btem_pkg::item_t        q_item,
    input  logic                   q_pop
);

    localparam int QW = $clog2(btem_pkg::QUEUE_DEPTH);

    btem_pkg::item_t mem_reg [btem_pkg::QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]     count_reg;
    logic            push;

    assign in_ch.ready = (count_reg != QW'(0) + (QW+1)'(btem_pkg::QUEUE_DEPTH)) ? 1'b1 : 1'b0;
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign q_item      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_ch.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QW+1)'(push) - (QW+1)'(q_pop);
        end
    end

endmodule

// File: rtl/core/btem_back.sv
module btem_back
#(
    parameter int GLYPH_ENTRIES = btem_pkg::GLYPH_ENTRIES_DEF,
    parameter int KERN_ENTRIES  = btem_pkg::KERN_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  btem_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  btem_pkg::item_t      q_item,
    output logic                 q_pop,
    btem_stream_if.source        out_ch
);

    localparam int GW   = $clog2(GLYPH_ENTRIES);
    localparam int KW   = $clog2(KERN_ENTRIES);
    localparam int CH   = btem_pkg::KERN_CHUNK;
    localparam int ROWS = (KERN_ENTRIES + CH - 1) / CH;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Glyph memory and kerning memory, chunk-wide rows.
    logic [31:0]        glyph_mem [GLYPH_ENTRIES];
    logic [CH*32-1:0]   kern_mem  [ROWS];
    logic [GLYPH_ENTRIES-1:0] glyph_present_reg;
    logic [KW:0]        kern_fill_reg;

    btem_pkg::back_state_t state_reg, state_next;
    btem_pkg::item_t     item_reg;
    logic [31:0]         glyph_rd_reg;
    logic [CH*32-1:0]    kern_rd_reg;
    logic [RW-1:0]       row_reg;
    logic                rd_pending_reg;
    logic                found_reg;
    logic signed [15:0]  kern_amt_reg;
    logic                have_glyph_reg;

    logic signed [20:0]  cur_w_reg, widest_reg;
    logic signed [20:0]  cur_h_reg, last_h_reg;
    logic [15:0]         closed_reg;
    logic [7:0]          prev_reg;
    logic                after_cr_reg, seen_reg;
    logic [25:0]         prod_reg;
    btem_pkg::result_t   res_reg;
    logic                out_valid_reg;

    logic [15:0] key;
    logic        row_hit;
    logic signed [15:0] row_amt;
    logic [KW:0] row_base;
    logic        last_row;

    assign key = (item_reg.action == btem_pkg::ACT_KERN) ? {item_reg.code, item_reg.second_code}
                                                        : {prev_reg, item_reg.code};
    assign row_base = (KW+1)'(row_reg) * (KW+1)'(CH);
    assign last_row = (row_base + (KW+1)'(CH) >= kern_fill_reg);

    always_comb
    begin
        row_hit = 1'b0;
        row_amt = '0;
        for (int i = CH - 1; i >= 0; i--)
        begin
            if ((row_base + (KW+1)'(i) < kern_fill_reg) && kern_rd_reg[i*32 +: 16] == key)
            begin
                row_hit = 1'b1;
                row_amt = kern_rd_reg[i*32+16 +: 16];
            end
        end
    end

    // Character arithmetic.
    logic signed [22:0] w_sum, new_w, sat_src;
    logic               wrap;
    logic signed [20:0] gh_ext, adv_ext;
    assign adv_ext = 21'(signed'(glyph_rd_reg[15:0]));
    assign gh_ext  = 21'(signed'(glyph_rd_reg[31:16]));
    assign w_sum   = 23'(adv_ext) + 23'(signed'(found_reg ? kern_amt_reg : 16'sd0));
    assign wrap    = cfg.wrap_enable &&
                     (23'(cur_w_reg) + w_sum >= signed'(23'({1'b0, cfg.max_width})));
    assign sat_src = (wrap ? 23'sd0 : 23'(cur_w_reg)) + w_sum;
    assign new_w   = (sat_src > 23'(btem_pkg::W21_MAX)) ? 23'(btem_pkg::W21_MAX) :
                     (sat_src < 23'(btem_pkg::W21_MIN)) ? 23'(btem_pkg::W21_MIN) : sat_src;

    logic signed [20:0] lh_ext;
    assign lh_ext = 21'({1'b0, cfg.line_height});

    // Only an end item has to wait for the output register to empty.
    assign q_pop          = (state_reg == btem_pkg::ST_IDLE) && q_valid &&
                            !(out_valid_reg && q_item.action == btem_pkg::ACT_END);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btem_pkg::ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_item.action)
                        btem_pkg::ACT_CHAR:  state_next = btem_pkg::ST_GLYPH_RD;
                        btem_pkg::ACT_END:   state_next = btem_pkg::ST_END_MUL;
                        btem_pkg::ACT_GLYPH: state_next = btem_pkg::ST_IDLE;
                        btem_pkg::ACT_KERN:  state_next = btem_pkg::ST_SCAN;
                        default:             state_next = btem_pkg::ST_IDLE;
                    endcase
                end
            end
            btem_pkg::ST_GLYPH_RD:
                state_next = btem_pkg::ST_SCAN;
            btem_pkg::ST_SCAN:
            begin
                if (kern_fill_reg == '0 || (rd_pending_reg && (row_hit || last_row)))
                begin
                    state_next = (item_reg.action == btem_pkg::ACT_KERN) ? btem_pkg::ST_IDLE
                                                                        : btem_pkg::ST_APPLY;
                end
            end
            btem_pkg::ST_APPLY:
                state_next = btem_pkg::ST_IDLE;
            btem_pkg::ST_END_MUL:
                state_next = btem_pkg::ST_OUT;
            btem_pkg::ST_OUT:
                state_next = btem_pkg::ST_IDLE;
            default:
                state_next = btem_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Memories.
    logic scan_found;
    assign scan_found = rd_pending_reg && row_hit;
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.action == btem_pkg::ACT_GLYPH && 32'(q_item.code) < GLYPH_ENTRIES)
        begin
            glyph_mem[GW'(q_item.code)] <= {q_item.glyph_height, q_item.amount};
        end
        if (q_pop)
        begin
            glyph_rd_reg <= glyph_mem[GW'(q_item.code)];
        end
        kern_rd_reg <= kern_mem[row_reg];
        if (state_reg == btem_pkg::ST_SCAN && item_reg.action == btem_pkg::ACT_KERN &&
            (kern_fill_reg == '0 || (rd_pending_reg && !row_hit && last_row)) &&
            kern_fill_reg < (KW+1)'(KERN_ENTRIES))
        begin
            kern_mem[RW'(kern_fill_reg / (KW+1)'(CH))][(kern_fill_reg % (KW+1)'(CH))*32 +: 32]
                <= {item_reg.amount, item_reg.code, item_reg.second_code};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_present_reg <= '0;
            kern_fill_reg     <= '0;
            item_reg          <= '0;
            row_reg           <= '0;
            rd_pending_reg    <= 1'b0;
            found_reg         <= 1'b0;
            kern_amt_reg      <= '0;
            have_glyph_reg    <= 1'b0;
            cur_w_reg         <= '0;
            widest_reg        <= '0;
            cur_h_reg         <= '0;
            last_h_reg        <= '0;
            closed_reg        <= '0;
            prev_reg          <= btem_pkg::CH_SPACE;
            after_cr_reg      <= 1'b0;
            seen_reg          <= 1'b0;
            prod_reg          <= '0;
            res_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                item_reg       <= q_item;
                row_reg        <= '0;
                rd_pending_reg <= 1'b0;
                found_reg      <= 1'b0;
                have_glyph_reg <= (32'(q_item.code) < GLYPH_ENTRIES) &&
                                  glyph_present_reg[GW'(q_item.code)];
                if (q_item.action == btem_pkg::ACT_GLYPH && 32'(q_item.code) < GLYPH_ENTRIES)
                begin
                    glyph_present_reg[GW'(q_item.code)] <= 1'b1;
                end
                if (q_item.action == btem_pkg::ACT_CHAR)
                begin
                    if (!seen_reg)
                    begin
                        cur_h_reg <= lh_ext;
                        seen_reg  <= 1'b1;
                    end
                end
            end
            if (state_reg == btem_pkg::ST_SCAN)
            begin
                if (scan_found)
                begin
                    found_reg    <= 1'b1;
                    kern_amt_reg <= row_amt;
                end
                else if (!(rd_pending_reg && last_row))
                begin
                    if (rd_pending_reg)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                    rd_pending_reg <= !rd_pending_reg;
                end
                if (item_reg.action == btem_pkg::ACT_KERN &&
                    (kern_fill_reg == '0 || (rd_pending_reg && !row_hit && last_row)) &&
                    kern_fill_reg < (KW+1)'(KERN_ENTRIES))
                begin
                    kern_fill_reg <= kern_fill_reg + 1'b1;
                end
            end
            if (state_reg == btem_pkg::ST_APPLY)
            begin
                if (item_reg.code == btem_pkg::CH_LF)
                begin
                    if (!after_cr_reg)
                    begin
                        if (cur_w_reg > widest_reg) widest_reg <= cur_w_reg;
                        last_h_reg <= cur_h_reg;
                        if (closed_reg != 16'hFFFF) closed_reg <= closed_reg + 1'b1;
                        cur_w_reg <= '0;
                        cur_h_reg <= lh_ext;
                    end
                    after_cr_reg <= 1'b0;
                end
                else if (item_reg.code == btem_pkg::CH_CR)
                begin
                    if (cur_w_reg > widest_reg) widest_reg <= cur_w_reg;
                    last_h_reg <= cur_h_reg;
                    if (closed_reg != 16'hFFFF) closed_reg <= closed_reg + 1'b1;
                    cur_w_reg    <= '0;
                    cur_h_reg    <= lh_ext;
                    after_cr_reg <= 1'b1;
                end
                else
                begin
                    after_cr_reg <= 1'b0;
                    prev_reg     <= item_reg.code;
                    if (have_glyph_reg)
                    begin
                        if (wrap)
                        begin
                            if (cur_w_reg > widest_reg) widest_reg <= cur_w_reg;
                            last_h_reg <= cur_h_reg;
                            if (closed_reg != 16'hFFFF) closed_reg <= closed_reg + 1'b1;
                        end
                        cur_w_reg <= 21'(new_w);
                        if (gh_ext > (wrap ? lh_ext : cur_h_reg))
                            cur_h_reg <= gh_ext;
                        else if (wrap)
                            cur_h_reg <= lh_ext;
                    end
                end
            end
            if (state_reg == btem_pkg::ST_END_MUL)
            begin
                if (cur_h_reg != '0)
                    prod_reg <= closed_reg * cfg.line_height;
                else
                    prod_reg <= (closed_reg - 16'(closed_reg != '0)) * cfg.line_height;
            end
            if (state_reg == btem_pkg::ST_OUT)
            begin
                logic signed [27:0] h;
                h = 28'(prod_reg) + ((cur_h_reg != '0) ? 28'(cur_h_reg) :
                    (closed_reg != '0) ? 28'(last_h_reg) : 28'sd0);
                if (!seen_reg || (cur_h_reg == '0 && closed_reg == '0))
                    h = '0;
                res_reg.block_width  <= !seen_reg ? 21'sd0 :
                                        (cur_w_reg > widest_reg ? cur_w_reg : widest_reg);
                res_reg.block_height <= (h < 0) ? 20'd0 :
                                        (h > 28'(btem_pkg::H20_MAX)) ? btem_pkg::H20_MAX : 20'(h);
                out_valid_reg <= 1'b1;
                cur_w_reg     <= '0;
                cur_h_reg     <= lh_ext;
                widest_reg    <= '0;
                closed_reg    <= '0;
                last_h_reg    <= '0;
                prev_reg      <= btem_pkg::CH_SPACE;
                after_cr_reg  <= 1'b0;
                seen_reg      <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/bitmap_text_extent_measure_top.sv
// A glyph write is done when it is taken, an end item goes through ST_END_MUL and ST_OUT to its
// result, a character goes through ST_GLYPH_RD, ST_SCAN and ST_APPLY, and a kerning write through
// ST_SCAN; the scan of the kerning table grows with its fill and ends early on a hit.
// Throughput: one item per back-end pass behind a two-entry queue; only an end item waits
// while an earlier result is still held in the output register.
// Reset (rst_n, async, active low) clears registers, valid bits and counts.
module bitmap_text_extent_measure_top
#(
    parameter int GLYPH_ENTRIES = btem_pkg::GLYPH_ENTRIES_DEF,
    parameter int KERN_ENTRIES  = btem_pkg::KERN_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    btem_stream_if.sink   in_ch,
    btem_stream_if.source out_ch
);

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    btem_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                btem_pkg::REG_LINE_HEIGHT: cfg_reg.line_height <= cfg_data[9:0];
                btem_pkg::REG_WRAP_ENABLE: cfg_reg.wrap_enable <= cfg_data[0];
                btem_pkg::REG_MAX_WIDTH:   cfg_reg.max_width   <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front stage queues accepted transactions; the back stage executes them.
    logic            q_valid, q_pop;
    btem_pkg::item_t q_item;

    btem_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    btem_back
    #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .KERN_ENTRIES  (KERN_ENTRIES)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

    // A result must hold while the consumer stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("result dropped under stall");

    // The back stage only takes a transaction that the queue holds.
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// File: test/tb_bitmap_text_extent_measure_top.sv
module tb_bitmap_text_extent_measure_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the measurement of one text at a time and holds the extents
    // that the block still owes us, in the order the end items went in.
    class text_extent_board;
        logic signed [15:0] glyph_adv [256];
        logic signed [15:0] glyph_hgt [256];
        bit                 glyph_ok [256];
        logic [15:0]        pair_key [256];
        logic signed [15:0] pair_amt [256];
        bit                 pair_ok [256];
        int                 pair_fill;

        int unsigned line_h;
        bit          wrap_on;
        int unsigned wrap_limit;

        longint      line_w;
        longint      line_ht;
        longint      widest;
        int unsigned lines_done;
        longint      last_done_ht;
        logic [7:0]  prev_code;
        bit          after_cr;
        bit          text_started;

        btem_pkg::result_t extent_q[$];
        int      errors;

        function new();
            foreach (glyph_ok[i]) glyph_ok[i] = 0;
            foreach (pair_ok[i]) pair_ok[i] = 0;
            pair_fill = 0;
            line_h = 0;
            wrap_on = 0;
            wrap_limit = 0;
            errors = 0;
            restart_text();
        endfunction

        function void restart_text();
            line_w = 0;
            line_ht = line_h;
            widest = 0;
            lines_done = 0;
            last_done_ht = 0;
            prev_code = btem_pkg::CH_SPACE;
            after_cr = 0;
            text_started = 0;
        endfunction

        function void set_reg(btem_pkg::reg_index_t idx, logic [15:0] data);
            case (idx)
                btem_pkg::REG_LINE_HEIGHT: line_h = data[9:0];
                btem_pkg::REG_WRAP_ENABLE: wrap_on = data[0];
                btem_pkg::REG_MAX_WIDTH:   wrap_limit = data;
                default: ;
            endcase
        endfunction

        function void break_line();
            if (line_w > widest)
                widest = line_w;
            last_done_ht = line_ht;
            if (lines_done < 65535)
                lines_done++;
            line_w = 0;
            line_ht = line_h;
        endfunction

        function longint kern_amount(logic [15:0] key);
            for (int i = 0; i < 256; i++)
                if (pair_ok[i] && pair_key[i] == key)
                    return pair_amt[i];
            return 0;
        endfunction

        function void add_char(logic [7:0] c);
            longint step;
            if (!text_started)
            begin
                line_ht = line_h;
                text_started = 1;
            end
            if (c == btem_pkg::CH_LF)
            begin
                if (!after_cr)
                    break_line();
                after_cr = 0;
                return;
            end
            if (c == btem_pkg::CH_CR)
            begin
                break_line();
                after_cr = 1;
                return;
            end
            after_cr = 0;
            if (glyph_ok[c])
            begin
                step = longint'(glyph_adv[c]) + kern_amount({prev_code, c});
                if (wrap_on && line_w + step >= longint'(wrap_limit))
                    break_line();
                line_w = line_w + step;
                if (line_w > 1048575)
                    line_w = 1048575;
                if (line_w < -1048576)
                    line_w = -1048576;
                if (longint'(glyph_hgt[c]) > line_ht)
                    line_ht = glyph_hgt[c];
            end
            prev_code = c;
        endfunction

        function void add_pair(logic [15:0] key, logic signed [15:0] amt);
            for (int i = 0; i < 256; i++)
                if (pair_ok[i] && pair_key[i] == key)
                    return;
            if (pair_fill >= 256)
                return;
            pair_key[pair_fill] = key;
            pair_amt[pair_fill] = amt;
            pair_ok[pair_fill] = 1;
            pair_fill++;
        endfunction

        function void note_input(btem_pkg::item_t it);
            longint w;
            longint h;
            btem_pkg::result_t r;
            case (it.action)
                btem_pkg::ACT_CHAR:  add_char(it.code);
                btem_pkg::ACT_GLYPH:
                begin
                    glyph_adv[it.code] = it.amount;
                    glyph_hgt[it.code] = it.glyph_height;
                    glyph_ok[it.code] = 1;
                end
                btem_pkg::ACT_KERN:  add_pair({it.code, it.second_code}, it.amount);
                default:
                begin
                    w = 0;
                    h = 0;
                    if (text_started)
                    begin
                        w = (line_w > widest) ? line_w : widest;
                        if (line_ht != 0)
                            h = longint'(lines_done) * line_h + line_ht;
                        else if (lines_done > 0)
                            h = longint'(lines_done - 1) * line_h + last_done_ht;
                        if (h < 0)
                            h = 0;
                        if (h > 1048575)
                            h = 1048575;
                    end
                    r.block_width = w[20:0];
                    r.block_height = h[19:0];
                    extent_q = {extent_q, r};
                    restart_text();
                end
            endcase
        endfunction

        function void check_result(btem_pkg::result_t got);
            btem_pkg::result_t want;
            if (extent_q.size() == 0)
            begin
                $display("%0t: unexpected result width=%0d height=%0d", $time,
                         got.block_width, got.block_height);
                errors++;
                return;
            end
            want = extent_q.pop_front();
            if (got.block_width !== want.block_width)
            begin
                $display("%0t: block_width expected %0d actual %0d", $time,
                         want.block_width, got.block_width);
                errors++;
            end
            if (got.block_height !== want.block_height)
            begin
                $display("%0t: block_height expected %0d actual %0d", $time,
                         want.block_height, got.block_height);
                errors++;
            end
        endfunction

        function int pending();
            return extent_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    btem_stream_if #(.payload_t(btem_pkg::item_t))   in_ch ();
    btem_stream_if #(.payload_t(btem_pkg::result_t)) out_ch ();

    bitmap_text_extent_measure_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    text_extent_board board;

    // When set, neither side inserts idle cycles, so the block runs back to back.
    bit no_idle;

    // A few codes that get glyphs and kerning pairs, so that random text
    // actually hits the stores instead of falling through as missing glyphs.
    logic [7:0] font_codes [10] = '{8'd32, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69,
                                    8'd70, 8'd71, 8'd72, 8'd255};

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Absolute limit on the run; the slowest legal run is far shorter.
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_cycles();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Inputs change at the falling edge; a transaction completes at the rising
    // edge where valid and ready are both high. Valid stays up between
    // back-to-back transactions so that it never toggles within one step.
    task automatic send_item(btem_pkg::item_t it);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_ch.valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_ch.payload = it;
        in_ch.valid = 1;
        do @(posedge clk); while (!in_ch.ready);
        board.note_input(it);
        @(negedge clk);
    endtask

    task automatic send_fields(btem_pkg::action_t act, logic [7:0] c, logic [7:0] c2,
                               logic signed [15:0] amt, logic signed [15:0] gh);
        btem_pkg::item_t it;
        it.action = act;
        it.code = c;
        it.second_code = c2;
        it.amount = amt;
        it.glyph_height = gh;
        send_item(it);
    endtask

    task automatic send_text_char(logic [7:0] c);
        send_fields(btem_pkg::ACT_CHAR, c, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_end();
        send_fields(btem_pkg::ACT_END, 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom));
    endtask

    // Waits until every owed result has come back, then gives the block time
    // to finish the characters that are still scanning the kerning table.
    task automatic drain();
        in_ch.valid = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(btem_pkg::reg_index_t idx, logic [15:0] data);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 0;
        board.set_reg(idx, data);
    endtask

    task automatic set_config(int lh, int wr, int mw);
        cfg_write(btem_pkg::REG_LINE_HEIGHT, 16'(lh));
        cfg_write(btem_pkg::REG_WRAP_ENABLE, 16'(wr));
        cfg_write(btem_pkg::REG_MAX_WIDTH, 16'(mw));
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) < 8)
            return font_codes[$urandom_range(0, 9)];
        return 8'($urandom);
    endfunction

    // Mostly text with line breaks and end marks, mixed with font updates.
    // Advances and heights are usually small so lines stay readable, with
    // occasional full-range values to hit the sign bit and saturation.
    function automatic btem_pkg::item_t random_item();
        btem_pkg::item_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it.code = pick_code();
        it.second_code = 8'($urandom);
        it.amount = 16'($urandom);
        it.glyph_height = 16'($urandom);
        if (sel < 62)
        begin
            it.action = btem_pkg::ACT_CHAR;
            if ($urandom_range(0, 9) == 0)
                it.code = ($urandom_range(0, 1) != 0) ? btem_pkg::CH_LF : btem_pkg::CH_CR;
        end
        else if (sel < 72)
            it.action = btem_pkg::ACT_END;
        else if (sel < 88)
        begin
            it.action = btem_pkg::ACT_GLYPH;
            if ($urandom_range(0, 4) != 0)
            begin
                it.amount = 16'($urandom_range(0, 40));
                it.glyph_height = 16'($urandom_range(0, 30));
            end
        end
        else
        begin
            it.action = btem_pkg::ACT_KERN;
            it.second_code = pick_code();
            if ($urandom_range(0, 4) != 0)
                it.amount = 16'(int'($urandom_range(0, 16)) - 8);
        end
        return it;
    endfunction

    // Result side: ready drops for a random number of cycles before each
    // transaction, and every result is checked as it completes.
    initial
    begin
        int n;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = idle_cycles();
            if (n > 0)
            begin
                out_ch.ready = 0;
                repeat (n) @(negedge clk);
            end
            out_ch.ready = 1;
            do @(posedge clk); while (!out_ch.valid);
            board.check_result(out_ch.payload);
        end
    end

    initial
    begin
        int lh_set [6] = '{16, 1023, 0, 7, 1023, 3};
        int wr_set [6] = '{1, 1, 0, 1, 0, 1};
        int mw_set [6] = '{100, 65535, 0, 0, 12, 300};

        board = new();
        no_idle = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = btem_pkg::REG_LINE_HEIGHT;
        cfg_data = 0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed part. An end with no text in front must report 0 by 0.
        send_end();
        drain();
        set_config(10, 1, 50);
        send_fields(btem_pkg::ACT_GLYPH, 8'd65, 8'd0, 16'sd20, 16'sd12);
        send_fields(btem_pkg::ACT_GLYPH, 8'd66, 8'hFF, 16'sh7FFF, 16'sh8000);
        send_fields(btem_pkg::ACT_GLYPH, 8'd255, 8'd0, 16'sh8000, 16'sh7FFF);
        send_fields(btem_pkg::ACT_GLYPH, 8'd67, 8'd0, 16'sd4, -16'sd5);
        // The second write of the same pair must not replace the first amount.
        send_fields(btem_pkg::ACT_KERN, 8'd65, 8'd66, -16'sd5, 16'sd0);
        send_fields(btem_pkg::ACT_KERN, 8'd65, 8'd66, 16'sd9, 16'sd0);
        send_fields(btem_pkg::ACT_KERN, 8'd32, 8'd65, 16'sd3, 16'sd0);
        send_text_char(8'd65);
        send_text_char(8'd66);
        // A carriage return swallows the line feed right after it only.
        send_text_char(btem_pkg::CH_CR);
        send_text_char(btem_pkg::CH_LF);
        send_text_char(btem_pkg::CH_LF);
        // A code with no glyph adds nothing but still becomes the previous code.
        send_text_char(8'd90);
        send_text_char(8'd65);
        send_text_char(8'd255);
        send_end();
        // Line height changed in the middle of a text: the value present at
        // the end mark applies to the earlier lines.
        send_text_char(8'd65);
        send_text_char(btem_pkg::CH_LF);
        send_text_char(8'd65);
        drain();
        cfg_write(btem_pkg::REG_LINE_HEIGHT, 16'd20);
        send_end();
        // With a zero line height and a negative glyph, the last line has no
        // height of its own and the last closed line stands in for it.
        drain();
        cfg_write(btem_pkg::REG_LINE_HEIGHT, 16'd0);
        send_text_char(8'd67);
        send_text_char(btem_pkg::CH_LF);
        send_text_char(8'd67);
        send_end();

        // Random phases, each under its own register setting. The pause
        // before each phase lets every owed result come back first.
        for (int p = 0; p < 6; p++)
        begin
            drain();
            set_config(lh_set[p], wr_set[p], mw_set[p]);
            no_idle = (p % 3 == 0);
            for (int i = 0; i < 150; i++)
                send_item(random_item());
        end
        send_end();
        no_idle = 0;

        // Fill the kerning store past its capacity; the overflow is dropped.
        for (int i = 0; i < 280; i++)
            send_fields(btem_pkg::ACT_KERN, 8'($urandom), 8'($urandom), 16'($urandom),
                        16'($urandom));

        // Long lines of the widest glyph drive the width into saturation,
        // first upward and then downward.
        drain();
        set_config(12, 0, 65535);
        send_fields(btem_pkg::ACT_GLYPH, 8'd87, 8'd0, 16'sh7FFF, 16'sd9);
        for (int i = 0; i < 34; i++)
            send_text_char(8'd87);
        send_end();
        send_fields(btem_pkg::ACT_GLYPH, 8'd87, 8'd0, 16'sh8000, 16'sd9);
        for (int i = 0; i < 34; i++)
            send_text_char(8'd87);
        send_end();

        // Many line breaks in a row at the tallest line height.
        drain();
        cfg_write(btem_pkg::REG_LINE_HEIGHT, 16'd1023);
        for (int i = 0; i < 200; i++)
            send_text_char(btem_pkg::CH_LF);
        send_end();

        // A last stretch of random text against the full kerning store.
        for (int i = 0; i < 60; i++)
            send_item(random_item());
        send_end();

        drain();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
